### sv/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// Shared constants, microcode word layout and control program of the biquad.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 20;
  localparam int COEF_FRAC       = 17;
  localparam int DELAY_BITS      = 32;
  // Holds any int64 intermediate plus one product without overflow.
  localparam int ACC_W           = 66;
  localparam int NUM_REGS        = 5;
  localparam int REG_IDX_W       = 3;
  localparam int STEP_W          = 4;

  // Register indexes, also used as coefficient selects in the microcode.
  localparam logic [REG_IDX_W-1:0] REG_FG0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FG1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FG2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BG1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BG2 = 3'd4;

  // Multiplier data operand selects.
  localparam logic [1:0] DS_D1 = 2'd0;
  localparam logic [1:0] DS_D2 = 2'd1;
  localparam logic [1:0] DS_W  = 2'd2;

  // Accumulator operations.
  localparam logic [2:0] AO_HOLD   = 3'd0;
  localparam logic [2:0] AO_LOAD_X = 3'd1;
  localparam logic [2:0] AO_LOAD_P = 3'd2;
  localparam logic [2:0] AO_ADD_P  = 3'd3;
  localparam logic [2:0] AO_SUB_P  = 3'd4;

  // Program addresses.
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_FB2   = 4'd1;
  localparam logic [STEP_W-1:0] S_FBACC = 4'd2;
  localparam logic [STEP_W-1:0] S_WRND  = 4'd3;
  localparam logic [STEP_W-1:0] S_FF0   = 4'd4;
  localparam logic [STEP_W-1:0] S_FF1   = 4'd5;
  localparam logic [STEP_W-1:0] S_FF2   = 4'd6;
  localparam logic [STEP_W-1:0] S_FFACC = 4'd7;
  localparam logic [STEP_W-1:0] S_EMIT  = 4'd8;

  typedef struct packed {
    logic [REG_IDX_W-1:0] coef_sel;
    logic [1:0]           data_sel;
    logic [2:0]           acc_op;
    logic                 round_w;  // round/saturate acc into w
    logic                 wait_in;  // hold until an input word arrives
    logic                 emit;     // hold until output register is free
    logic                 last;     // jump back to start
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } seq_cond_t;

  typedef struct packed {
    ucode_t uc;
    logic   fire;  // current step executes this cycle
  } seq_ctl_t;

  function automatic ucode_t uc_word(input logic [REG_IDX_W-1:0] cs,
                                     input logic [1:0] ds,
                                     input logic [2:0] ao,
                                     input logic rw, input logic wi,
                                     input logic em, input logic ls);
    ucode_t u;
    u.coef_sel = cs;
    u.data_sel = ds;
    u.acc_op   = ao;
    u.round_w  = rw;
    u.wait_in  = wi;
    u.emit     = em;
    u.last     = ls;
    return u;
  endfunction

  // Control program. The multiplier result is registered, so the product
  // issued in one step is accumulated in the next.
  function automatic ucode_t biq_ucode(input logic [STEP_W-1:0] step);
    ucode_t u;
    unique case (step)
      S_IDLE:  u = uc_word(REG_BG1, DS_D1, AO_LOAD_X, 1'b0, 1'b1, 1'b0, 1'b0);
      S_FB2:   u = uc_word(REG_BG2, DS_D2, AO_SUB_P,  1'b0, 1'b0, 1'b0, 1'b0);
      S_FBACC: u = uc_word(REG_BG2, DS_D2, AO_SUB_P,  1'b0, 1'b0, 1'b0, 1'b0);
      S_WRND:  u = uc_word(REG_FG0, DS_W,  AO_HOLD,   1'b1, 1'b0, 1'b0, 1'b0);
      S_FF0:   u = uc_word(REG_FG0, DS_W,  AO_HOLD,   1'b0, 1'b0, 1'b0, 1'b0);
      S_FF1:   u = uc_word(REG_FG1, DS_D1, AO_LOAD_P, 1'b0, 1'b0, 1'b0, 1'b0);
      S_FF2:   u = uc_word(REG_FG2, DS_D2, AO_ADD_P,  1'b0, 1'b0, 1'b0, 1'b0);
      S_FFACC: u = uc_word(REG_FG2, DS_D2, AO_ADD_P,  1'b0, 1'b0, 1'b0, 1'b0);
      S_EMIT:  u = uc_word(REG_FG0, DS_D1, AO_HOLD,   1'b0, 1'b0, 1'b1, 1'b1);
      default: u = uc_word(REG_FG0, DS_D1, AO_HOLD,   1'b0, 1'b0, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

### sv/biq_if.sv
// ----------------------------------------------------------------------------
// biq_if
// Valid/ready channels of the biquad: sample in, sample out, register write.
// ----------------------------------------------------------------------------
interface biq_in_if #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface biq_cfg_if #(
  parameter int COEF_BITS = biq_pkg::COEF_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [biq_pkg::REG_IDX_W-1:0]  index;
  logic [COEF_BITS-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/biq_seq.sv
// ----------------------------------------------------------------------------
// biq_seq
// Step counter and microcode table; stalls on the wait/emit conditions.
// ----------------------------------------------------------------------------
module biq_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  biq_pkg::seq_cond_t cond,
  output biq_pkg::seq_ctl_t  ctl
);
  import biq_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uc;
  logic              fire;

  always_comb begin
    uc = biq_ucode(step_r);
    priority if (uc.wait_in) begin
      fire = cond.in_valid;
    end else if (uc.emit) begin
      fire = cond.out_free;
    end else begin
      fire = 1'b1;
    end
    priority if (!fire) begin
      step_nxt = step_r;
    end else if (uc.last) begin
      step_nxt = S_IDLE;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.uc   = uc;
  assign ctl.fire = fire;

endmodule

### sv/biq_datapath.sv
// ----------------------------------------------------------------------------
// biq_datapath
// Shared multiplier, saturating accumulator, rounding and the delay line.
// ----------------------------------------------------------------------------
module biq_datapath #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  biq_pkg::seq_ctl_t                             ctl,
  input  logic [biq_pkg::NUM_REGS-1:0][COEF_BITS-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0]                 sample_in,
  output logic signed [SAMPLE_BITS-1:0]                 y_val,
  output logic                                          y_clip
);
  import biq_pkg::*;

  localparam int PW = COEF_BITS + DELAY_BITS;

  localparam logic signed [ACC_W-1:0] MAX64 = {{(ACC_W-63){1'b0}}, {63{1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN64 = ~MAX64;
  localparam logic signed [ACC_W-1:0] HALF  =
    {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] W_HI  =
    {{(ACC_W-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] W_LO  = ~W_HI;
  localparam logic signed [ACC_W-1:0] Y_HI  =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_LO  = ~Y_HI;

  function automatic logic signed [ACC_W-1:0] sat64(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    priority if (v > MAX64) begin
      r = MAX64;
    end else if (v < MIN64) begin
      r = MIN64;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [PW-1:0]         prod_r;
  logic signed [DELAY_BITS-1:0] d1_r, d2_r, w_r;
  logic                         clip_r;

  logic signed [COEF_BITS-1:0]  mul_a;
  logic signed [DELAY_BITS-1:0] mul_b;
  logic signed [ACC_W-1:0]      prod_ext, x_ext, rnd_v;
  logic signed [DELAY_BITS-1:0] w_sat;
  logic                         w_clip;

  always_comb begin
    mul_a = coef[ctl.uc.coef_sel];
    unique case (ctl.uc.data_sel)
      DS_D1:   mul_b = d1_r;
      DS_D2:   mul_b = d2_r;
      DS_W:    mul_b = w_r;
      default: mul_b = d1_r;
    endcase
  end

  assign prod_ext = {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
  assign x_ext    = {{(ACC_W-SAMPLE_BITS-COEF_FRAC){sample_in[SAMPLE_BITS-1]}},
                     sample_in, {COEF_FRAC{1'b0}}};

  always_comb begin
    unique case (ctl.uc.acc_op)
      AO_LOAD_X: acc_nxt = x_ext;
      AO_LOAD_P: acc_nxt = prod_ext;
      AO_ADD_P:  acc_nxt = sat64(acc_r + prod_ext);
      AO_SUB_P:  acc_nxt = sat64(acc_r - prod_ext);
      default:   acc_nxt = acc_r;
    endcase
  end

  // Round half up, then saturate to the delay or the sample range.
  always_comb begin
    rnd_v = sat64(acc_r + HALF) >>> COEF_FRAC;
    priority if (rnd_v > W_HI) begin
      w_sat  = W_HI[DELAY_BITS-1:0];
      w_clip = 1'b1;
    end else if (rnd_v < W_LO) begin
      w_sat  = W_LO[DELAY_BITS-1:0];
      w_clip = 1'b1;
    end else begin
      w_sat  = rnd_v[DELAY_BITS-1:0];
      w_clip = 1'b0;
    end
    priority if (rnd_v > Y_HI) begin
      y_val  = Y_HI[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else if (rnd_v < Y_LO) begin
      y_val  = Y_LO[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else begin
      y_val  = rnd_v[SAMPLE_BITS-1:0];
      y_clip = clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      prod_r <= mul_a * mul_b;
      acc_r  <= acc_nxt;
      if (ctl.uc.round_w) begin
        w_r <= w_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r   <= '0;
      d2_r   <= '0;
      clip_r <= 1'b0;
    end else if (ctl.fire) begin
      if (ctl.uc.wait_in) begin
        clip_r <= 1'b0;
      end else if (ctl.uc.round_w) begin
        clip_r <= w_clip;
      end
      if (ctl.uc.emit) begin
        d2_r <= d1_r;
        d1_r <= w_r;
      end
    end
  end

endmodule

### sv/biquad_iir_filter_top.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_top
// Direct form II biquad section, fixed point, microcoded on one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one sample word (signed Q1.23) per handshake.
//   out_chan : one filtered word per input word, plus a clipped flag that is
//              set when the internal value or the output saturated.
//   cfg_chan : coefficient writes (index 0..4 = b0, b1, b2, a1, a2, 17
//              fraction bits). Write only while no sample is in flight.
//              Indexes above 4 are ignored. Always ready.
// Timing:
//   A word is accepted in the idle step; its result lands in the output
//   register at the emit step, and the next word can be accepted in the cycle
//   after that, so a new word is taken only once the program is through with
//   the last one. The step sequence is set by the single shared multiplier:
//   five products, each registered before accumulation, plus the rounding steps for w and y.
// Reset (rst_n low, synchronous): coefficients go to b0 = 1.0, others 0,
//   delays to 0, output register empty, program at the idle step.
// Stall: the output register lets the next word be accepted while a
//   result waits; the program then holds at its emit step until the
//   receiver takes the pending word.
// ----------------------------------------------------------------------------
module biquad_iir_filter_top #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  biq_in_if.sink     in_chan,
  biq_out_if.source  out_chan,
  biq_cfg_if.sink    cfg_chan
);
  import biq_pkg::*;

  // Reset coefficient set: b0 = 1.0 in the lowest slot, the rest zero.
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
  localparam logic [NUM_REGS-1:0][COEF_BITS-1:0] COEF_RST =
    {{((NUM_REGS-1)*COEF_BITS){1'b0}}, COEF_ONE};

  // Coefficient registers, indexed by register number.
  logic [NUM_REGS-1:0][COEF_BITS-1:0] coef_r;

  // Output register.
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic                          clipped_r;

  seq_cond_t                     cond;
  seq_ctl_t                      ctl;
  logic signed [SAMPLE_BITS-1:0] y_val;
  logic                          y_clip;
  logic                          emit_fire;

  assign cond.in_valid = in_chan.valid;
  assign cond.out_free = !out_valid_r || out_chan.ready;

  biq_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  biq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .coef      (coef_r),
    .sample_in (in_chan.sample_in),
    .y_val     (y_val),
    .y_clip    (y_clip)
  );

  // Input is taken only at the idle step of the program.
  assign in_chan.ready = ctl.uc.wait_in;
  assign emit_fire     = ctl.fire && ctl.uc.emit;

  // Coefficient writes; unknown indexes drop.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      if (cfg_chan.index < REG_IDX_W'(NUM_REGS)) begin
        coef_r[cfg_chan.index] <= cfg_chan.data;
      end
    end
  end

  // Output register: loaded at the emit step, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      sample_out_r <= y_val;
      clipped_r    <= y_clip;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = sample_out_r;
  assign out_chan.clipped    = clipped_r;

`ifndef SYNTHESIS
  // One word at a time: no second accept right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while a word is in flight");

  // A result only appears through the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit_fire))
    else $error("output valid without emit step");

  // An emit always leaves a valid word in the output register.
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid_r)
    else $error("emitted word lost");

  // The emit step never overwrites a word the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !emit_fire)
    else $error("pending output overwritten");
`endif

endmodule
